// File: sv/bhdt_pkg.sv
// Shared types and constants for the button hold duration tracker.
// Used by bhdt_counters, bhdt_query, button_hold_duration_tracker, duration_checker and tb.
// No dependencies.
package bhdt_pkg;

  // Run counter width and its symmetric saturation limit
  localparam int unsigned COUNT_WIDTH = 16;
  localparam int unsigned NUM_KEYS    = 14;
  localparam int unsigned KEY_IDX_W   = 4;

  // Result width and the width used while forming a query result
  localparam int unsigned OUT_WIDTH   = 16;
  localparam int unsigned QUERY_WIDTH = (COUNT_WIDTH > OUT_WIDTH) ? COUNT_WIDTH : OUT_WIDTH;

  typedef logic signed [COUNT_WIDTH-1:0] count_t;
  typedef count_t [NUM_KEYS-1:0]         count_arr_t;
  typedef logic [KEY_IDX_W-1:0]          key_idx_t;
  typedef logic signed [OUT_WIDTH-1:0]   duration_t;
  typedef logic signed [QUERY_WIDTH-1:0] query_val_t;

  localparam count_t COUNT_LIMIT = count_t'((64'd1 << (COUNT_WIDTH - 1)) - 64'd1);
  localparam count_t COUNT_ONE   = count_t'(1);
  localparam query_val_t OUT_LIMIT = query_val_t'(32767);

  // Operation codes
  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Counter slots
  localparam key_idx_t IDX_BACK = 4'd0;
  localparam key_idx_t IDX_DOWN = 4'd1;
  localparam key_idx_t IDX_FWD  = 4'd2;
  localparam key_idx_t IDX_UP   = 4'd3;

  // Status word bits
  localparam int unsigned ST_UP    = 0;
  localparam int unsigned ST_DOWN  = 1;
  localparam int unsigned ST_SIDE0 = 2;
  localparam int unsigned ST_SIDE1 = 3;

  // Key codes
  localparam logic [5:0] KEY_B         = 6'd0;
  localparam logic [5:0] KEY_D         = 6'd1;
  localparam logic [5:0] KEY_F         = 6'd2;
  localparam logic [5:0] KEY_U         = 6'd3;
  localparam logic [5:0] KEY_DB        = 6'd4;
  localparam logic [5:0] KEY_UB        = 6'd5;
  localparam logic [5:0] KEY_DF        = 6'd6;
  localparam logic [5:0] KEY_UF        = 6'd7;
  localparam logic [5:0] KEY_SB        = 6'd8;
  localparam logic [5:0] KEY_SD        = 6'd9;
  localparam logic [5:0] KEY_SF        = 6'd10;
  localparam logic [5:0] KEY_SU        = 6'd11;
  localparam logic [5:0] KEY_SDB       = 6'd12;
  localparam logic [5:0] KEY_SUB       = 6'd13;
  localparam logic [5:0] KEY_SDF       = 6'd14;
  localparam logic [5:0] KEY_SUF       = 6'd15;
  localparam logic [5:0] KEY_BTN_FIRST = 6'd16;
  localparam logic [5:0] KEY_BTN_LAST  = 6'd25;
  localparam logic [5:0] KEY_NEG_FIRST = 6'd26;
  localparam logic [5:0] KEY_NEG_LAST  = 6'd37;
  localparam logic [5:0] BTN_KEY_OFFSET = 6'd12;

  // Frame tick as handed to the counter bank
  typedef struct packed {
    logic        en;
    logic [13:0] status;
    logic        facing_left;
  } tick_t;

endpackage

// File: sv/bhdt_counters.sv
// Bank of 14 saturating signed run counters with held flags.
// Depends on bhdt_pkg.
module bhdt_counters (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bhdt_pkg::tick_t     tick_i,
  output bhdt_pkg::count_arr_t counts_o
);

  logic [bhdt_pkg::NUM_KEYS-1:0] pressed;
  logic [bhdt_pkg::NUM_KEYS-1:0] held_q, held_d;
  bhdt_pkg::count_arr_t          count_q, count_d;
  logic                          bk, fw, up, dn;

  // Resolve facing and cancel opposite directions
  always_comb begin
    bk = tick_i.facing_left ? tick_i.status[bhdt_pkg::ST_SIDE1]
                            : tick_i.status[bhdt_pkg::ST_SIDE0];
    fw = tick_i.facing_left ? tick_i.status[bhdt_pkg::ST_SIDE0]
                            : tick_i.status[bhdt_pkg::ST_SIDE1];
    up = tick_i.status[bhdt_pkg::ST_UP];
    dn = tick_i.status[bhdt_pkg::ST_DOWN];
    pressed = tick_i.status;
    pressed[bhdt_pkg::IDX_BACK] = bk & ~fw;
    pressed[bhdt_pkg::IDX_DOWN] = dn & ~up;
    pressed[bhdt_pkg::IDX_FWD]  = fw & ~bk;
    pressed[bhdt_pkg::IDX_UP]   = up & ~dn;
  end

  // Restart on a change, otherwise step toward the held direction and saturate
  always_comb begin
    held_d  = held_q;
    count_d = count_q;
    if (tick_i.en) begin
      for (int i = 0; i < bhdt_pkg::NUM_KEYS; i++) begin
        held_d[i] = pressed[i];
        if (pressed[i] != held_q[i]) begin
          count_d[i] = pressed[i] ? bhdt_pkg::COUNT_ONE : -bhdt_pkg::COUNT_ONE;
        end else if (held_q[i]) begin
          if (count_q[i] != bhdt_pkg::COUNT_LIMIT) begin
            count_d[i] = count_q[i] + bhdt_pkg::COUNT_ONE;
          end
        end else begin
          if (count_q[i] != -bhdt_pkg::COUNT_LIMIT) begin
            count_d[i] = count_q[i] - bhdt_pkg::COUNT_ONE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= '0;
      count_q <= '0;
    end else begin
      held_q  <= held_d;
      count_q <= count_d;
    end
  end

  assign counts_o = count_q;

endmodule

// File: sv/bhdt_query.sv
// Forms the duration for one key code from the run counters.
// Depends on bhdt_pkg.
module bhdt_query (
  input  bhdt_pkg::count_arr_t counts_i,
  input  logic [5:0]           key_code_i,
  output bhdt_pkg::duration_t  duration_o
);

  function automatic bhdt_pkg::query_val_t mx(bhdt_pkg::query_val_t a,
                                              bhdt_pkg::query_val_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic bhdt_pkg::query_val_t mn(bhdt_pkg::query_val_t a,
                                              bhdt_pkg::query_val_t b);
    return (a < b) ? a : b;
  endfunction

  bhdt_pkg::query_val_t cb, cd, cf, cu, sel, res;
  logic                 neg;
  logic [5:0]           base;
  logic [5:0]           btn_off;

  // Sign-extend direction counters
  assign cb = bhdt_pkg::query_val_t'(counts_i[bhdt_pkg::IDX_BACK]);
  assign cd = bhdt_pkg::query_val_t'(counts_i[bhdt_pkg::IDX_DOWN]);
  assign cf = bhdt_pkg::query_val_t'(counts_i[bhdt_pkg::IDX_FWD]);
  assign cu = bhdt_pkg::query_val_t'(counts_i[bhdt_pkg::IDX_UP]);

  // Fold negated keys onto their plain form
  assign neg  = (key_code_i >= bhdt_pkg::KEY_NEG_FIRST) &&
                (key_code_i <= bhdt_pkg::KEY_NEG_LAST);
  assign base = neg ? (key_code_i - bhdt_pkg::KEY_NEG_FIRST) : key_code_i;
  assign btn_off = base - bhdt_pkg::BTN_KEY_OFFSET;

  // Select the base duration
  always_comb begin
    case (base)
      bhdt_pkg::KEY_B:   sel = mn(-mx(cd, cu), cb);
      bhdt_pkg::KEY_D:   sel = mn(-mx(cb, cf), cd);
      bhdt_pkg::KEY_F:   sel = mn(-mx(cd, cu), cf);
      bhdt_pkg::KEY_U:   sel = mn(-mx(cb, cf), cu);
      bhdt_pkg::KEY_DB:  sel = mn(cd, cb);
      bhdt_pkg::KEY_UB:  sel = mn(cu, cb);
      bhdt_pkg::KEY_DF:  sel = mn(cd, cf);
      bhdt_pkg::KEY_UF:  sel = mn(cu, cf);
      bhdt_pkg::KEY_SB:  sel = cb;
      bhdt_pkg::KEY_SD:  sel = cd;
      bhdt_pkg::KEY_SF:  sel = cf;
      bhdt_pkg::KEY_SU:  sel = cu;
      bhdt_pkg::KEY_SDB: sel = mn(-mx(cu, cf), mx(cd, cb));
      bhdt_pkg::KEY_SUB: sel = mn(-mx(cd, cf), mx(cu, cb));
      bhdt_pkg::KEY_SDF: sel = mn(-mx(cu, cb), mx(cd, cf));
      bhdt_pkg::KEY_SUF: sel = mn(-mx(cd, cb), mx(cu, cf));
      default: begin
        if (base >= bhdt_pkg::KEY_BTN_FIRST && base <= bhdt_pkg::KEY_BTN_LAST) begin
          sel = bhdt_pkg::query_val_t'(counts_i[btn_off[bhdt_pkg::KEY_IDX_W-1:0]]);
        end else begin
          sel = '0;
        end
      end
    endcase
  end

  // Apply negation and clip to the result range
  always_comb begin
    res = neg ? -sel : sel;
    if (res > bhdt_pkg::OUT_LIMIT) begin
      res = bhdt_pkg::OUT_LIMIT;
    end else if (res < -bhdt_pkg::OUT_LIMIT) begin
      res = -bhdt_pkg::OUT_LIMIT;
    end
  end

  assign duration_o = res[bhdt_pkg::OUT_WIDTH-1:0];

endmodule

// File: sv/button_hold_duration_tracker.sv
// Button hold duration tracker: input register, counter bank and query logic, result register.
// Depends on bhdt_pkg, bhdt_counters and bhdt_query.
// A query passes from the input register to the result register; while the result register
// holds a stalled result, the query waits in the input register.
// Throughput: one item per cycle; the input stalls only while a query waits on a held result.
// Reset clears all run counters to 0, all held flags to released and both valid flags.
module button_hold_duration_tracker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                func_i,
  input  logic [13:0]         status_word_i,
  input  logic                facing_left_i,
  input  logic [5:0]          key_code_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bhdt_pkg::duration_t duration_o
);

  logic                 s1_valid_q, s1_valid_d;
  logic                 s1_func_q;
  logic [13:0]          s1_status_q;
  logic                 s1_facing_q;
  logic [5:0]           s1_key_q;
  logic                 out_valid_q, out_valid_d;
  bhdt_pkg::duration_t  duration_q;
  bhdt_pkg::duration_t  query_dur;
  bhdt_pkg::count_arr_t counts;
  bhdt_pkg::tick_t      tick;
  logic                 out_free, s1_move, in_xfer, out_load;

  // Handshake between the stages
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_move    = (s1_func_q == bhdt_pkg::FUNC_TICK) || out_free;
  assign in_stall_o = s1_valid_q && !s1_move;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_load   = s1_valid_q && (s1_func_q == bhdt_pkg::FUNC_QUERY) && out_free;

  assign s1_valid_d  = in_xfer || (s1_valid_q && !s1_move);
  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_func_q   <= func_i;
      s1_status_q <= status_word_i;
      s1_facing_q <= facing_left_i;
      s1_key_q    <= key_code_i;
    end
  end

  // Apply a tick to the counters
  always_comb begin
    tick.en          = s1_valid_q && (s1_func_q == bhdt_pkg::FUNC_TICK);
    tick.status      = s1_status_q;
    tick.facing_left = s1_facing_q;
  end

  bhdt_counters u_counters (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tick_i   (tick),
    .counts_o (counts)
  );

  bhdt_query u_query (
    .counts_i   (counts),
    .key_code_i (s1_key_q),
    .duration_o (query_dur)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      duration_q <= query_dur;
    end
  end

  assign out_valid_o = out_valid_q;
  assign duration_o  = duration_q;

  // Only a query waiting on a held result may stall the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && s1_func_q == bhdt_pkg::FUNC_QUERY && out_valid_q))
    else $error("input stalled without a blocked query");

  // A query leaving the input register shows up as a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_func_q == bhdt_pkg::FUNC_QUERY && !in_stall_o) |=> out_valid_q)
    else $error("query lost between stages");

  // A tick never produces a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_func_q == bhdt_pkg::FUNC_TICK && out_free) |=> !out_valid_q)
    else $error("tick produced a result");

endmodule

// File: sim/duration_checker.sv
// Checker for the button hold duration tracker: watches both channels, keeps its
// own run counters and compares every returned duration with its prediction.
// Depends on bhdt_pkg.
module duration_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic                func_i,
  input  logic [13:0]         status_word_i,
  input  logic                facing_left_i,
  input  logic [5:0]          key_code_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  bhdt_pkg::duration_t duration_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [5:0]          key;
    bhdt_pkg::duration_t value;
  } due_t;

  due_t             durations_due[$];
  bhdt_pkg::count_t run_cnt[bhdt_pkg::NUM_KEYS];
  logic             held[bhdt_pkg::NUM_KEYS];
  int               fails;

  function automatic longint lo(longint a, longint b);
    return (a < b) ? a : b;
  endfunction

  function automatic longint hi(longint a, longint b);
    return (a > b) ? a : b;
  endfunction

  // Restart the run on a change, then step toward the held state and saturate
  function automatic void advance_count(int idx, logic pressed);
    longint v;
    longint lim;
    longint step;
    lim = longint'(bhdt_pkg::COUNT_LIMIT);
    if (pressed != held[idx]) begin
      held[idx] = pressed;
      run_cnt[idx] = '0;
    end
    step = held[idx] ? 1 : -1;
    v = longint'(run_cnt[idx]) + step;
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    run_cnt[idx] = bhdt_pkg::count_t'(v);
  endfunction

  // Resolve facing, cancel opposite directions, then advance every counter
  function automatic void apply_tick(logic [13:0] status, logic facing);
    logic side_b;
    logic side_f;
    logic up;
    logic dn;
    side_b = facing ? status[bhdt_pkg::ST_SIDE1] : status[bhdt_pkg::ST_SIDE0];
    side_f = facing ? status[bhdt_pkg::ST_SIDE0] : status[bhdt_pkg::ST_SIDE1];
    up = status[bhdt_pkg::ST_UP];
    dn = status[bhdt_pkg::ST_DOWN];
    advance_count(bhdt_pkg::IDX_BACK, side_b && !side_f);
    advance_count(bhdt_pkg::IDX_DOWN, dn && !up);
    advance_count(bhdt_pkg::IDX_FWD, side_f && !side_b);
    advance_count(bhdt_pkg::IDX_UP, up && !dn);
    for (int i = 4; i < bhdt_pkg::NUM_KEYS; i++) advance_count(i, status[i]);
  endfunction

  // Lenient, diagonal and strict direction durations; anything else reads 0
  function automatic longint direction_duration(logic [5:0] k);
    longint cb;
    longint cd;
    longint cf;
    longint cu;
    cb = run_cnt[bhdt_pkg::IDX_BACK];
    cd = run_cnt[bhdt_pkg::IDX_DOWN];
    cf = run_cnt[bhdt_pkg::IDX_FWD];
    cu = run_cnt[bhdt_pkg::IDX_UP];
    case (k)
      bhdt_pkg::KEY_B:   return lo(-hi(cd, cu), cb);
      bhdt_pkg::KEY_D:   return lo(-hi(cb, cf), cd);
      bhdt_pkg::KEY_F:   return lo(-hi(cd, cu), cf);
      bhdt_pkg::KEY_U:   return lo(-hi(cb, cf), cu);
      bhdt_pkg::KEY_DB:  return lo(cd, cb);
      bhdt_pkg::KEY_UB:  return lo(cu, cb);
      bhdt_pkg::KEY_DF:  return lo(cd, cf);
      bhdt_pkg::KEY_UF:  return lo(cu, cf);
      bhdt_pkg::KEY_SB:  return cb;
      bhdt_pkg::KEY_SD:  return cd;
      bhdt_pkg::KEY_SF:  return cf;
      bhdt_pkg::KEY_SU:  return cu;
      bhdt_pkg::KEY_SDB: return lo(-hi(cu, cf), hi(cd, cb));
      bhdt_pkg::KEY_SUB: return lo(-hi(cd, cf), hi(cu, cb));
      bhdt_pkg::KEY_SDF: return lo(-hi(cu, cb), hi(cd, cf));
      bhdt_pkg::KEY_SUF: return lo(-hi(cd, cb), hi(cu, cf));
      default: return 0;
    endcase
  endfunction

  function automatic bhdt_pkg::duration_t key_duration(logic [5:0] k);
    longint d;
    longint lim;
    lim = longint'(bhdt_pkg::OUT_LIMIT);
    if (k >= bhdt_pkg::KEY_NEG_FIRST && k <= bhdt_pkg::KEY_NEG_LAST) begin
      d = -direction_duration(k - bhdt_pkg::KEY_NEG_FIRST);
    end else if (k >= bhdt_pkg::KEY_BTN_FIRST && k <= bhdt_pkg::KEY_BTN_LAST) begin
      d = run_cnt[k - bhdt_pkg::BTN_KEY_OFFSET];
    end else begin
      d = direction_duration(k);
    end
    if (d > lim) d = lim;
    if (d < -lim) d = -lim;
    return bhdt_pkg::duration_t'(d);
  endfunction

  // Compare the returned transfer, then fold in the accepted item
  always @(posedge clk_i or negedge rst_ni) begin
    due_t due;
    if (!rst_ni) begin
      for (int i = 0; i < bhdt_pkg::NUM_KEYS; i++) begin
        run_cnt[i] = '0;
        held[i] = 1'b0;
      end
      durations_due.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (durations_due.size() == 0) begin
          $display("%0t: unexpected duration: expected none, actual %0d", $time, duration_i);
          fails++;
        end else begin
          due = durations_due.pop_front();
          if (duration_i !== due.value) begin
            $display("%0t: duration mismatch for key %0d: expected %0d, actual %0d",
                     $time, due.key, due.value, duration_i);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (func_i == bhdt_pkg::FUNC_TICK) begin
          apply_tick(status_word_i, facing_left_i);
        end else begin
          due.key = key_code_i;
          due.value = key_duration(key_code_i);
          durations_due.insert(durations_due.size(), due);
        end
      end
      fail_count_o <= fails;
      pending_o <= durations_due.size();
    end
  end

endmodule

// File: sim/tb.sv
// Testbench top for the button hold duration tracker: clock, reset, frame and
// query stimulus, receiver stalls and the final verdict.
// Depends on bhdt_pkg, button_hold_duration_tracker and duration_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES    = 300;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int RUN_TICKS      = 200;
  localparam int RAND_PER_PHASE = 150;
  localparam int IDLE_PCT[4]    = '{0, 80, 0, 37};
  localparam int STALL_PCT[4]   = '{0, 0, 80, 37};

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                func_i = bhdt_pkg::FUNC_TICK;
  logic [13:0]         status_word_i = '0;
  logic                facing_left_i = 1'b0;
  logic [5:0]          key_code_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  bhdt_pkg::duration_t duration_o;

  int          fail_count;
  int          pending;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          hold_seq = 0;
  int          cycle_count = 0;
  logic [13:0] cur_status = '0;
  logic        cur_facing = 1'b0;

  button_hold_duration_tracker u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .status_word_i (status_word_i),
    .facing_left_i (facing_left_i),
    .key_code_i    (key_code_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .duration_o    (duration_o)
  );

  duration_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .func_i        (func_i),
    .status_word_i (status_word_i),
    .facing_left_i (facing_left_i),
    .key_code_i    (key_code_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .duration_i    (duration_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always #5 clk_i = ~clk_i;

  // Receiver: random stalls, or a long hold-off each time one is requested
  initial begin
    int hold_seen;
    hold_seen = 0;
    forever begin
      @(posedge clk_i);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Abort a hung run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("button_hold_duration_tracker verification failed");
    $finish;
  end

  // Offer one item after random idle cycles and hold it until the transfer
  task automatic send_item(logic fn, logic [13:0] st, logic fl, logic [5:0] key);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= fn;
    status_word_i <= st;
    facing_left_i <= fl;
    key_code_i <= key;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drop valid and wait until every query has returned its duration
  task automatic wait_results_clear();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [5:0] pick_key();
    return ($urandom_range(99) < 85) ? 6'($urandom_range(37)) : 6'($urandom_range(63));
  endfunction

  // Mostly held status words so runs grow, with edits, facing flips and queries
  task automatic random_item();
    if ($urandom_range(99) < 55) begin
      case ($urandom_range(9))
        0:       cur_status = 14'($urandom);
        1, 2:    cur_status = cur_status ^ 14'(1 << $urandom_range(13));
        3:       cur_facing = ~cur_facing;
        default: ;
      endcase
      send_item(bhdt_pkg::FUNC_TICK, cur_status, cur_facing, 6'($urandom));
    end else begin
      send_item(bhdt_pkg::FUNC_QUERY, 14'($urandom), 1'($urandom), pick_key());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: query before any frame, facing, cancellation, every key group
    send_item(bhdt_pkg::FUNC_QUERY, '0, 1'b0, bhdt_pkg::KEY_U);
    send_item(bhdt_pkg::FUNC_TICK, '0, 1'b0, '0);
    send_item(bhdt_pkg::FUNC_TICK, 14'h3FFF, 1'b0, '0);
    send_item(bhdt_pkg::FUNC_TICK, 14'h3FFF, 1'b1, '0);
    send_item(bhdt_pkg::FUNC_QUERY, '0, 1'b0, bhdt_pkg::KEY_B);
    send_item(bhdt_pkg::FUNC_TICK, 14'h0005, 1'b0, '0);
    send_item(bhdt_pkg::FUNC_TICK, 14'h0005, 1'b0, '0);
    send_item(bhdt_pkg::FUNC_QUERY, '0, 1'b0, bhdt_pkg::KEY_UB);
    send_item(bhdt_pkg::FUNC_TICK, 14'h0005, 1'b1, '0);
    send_item(bhdt_pkg::FUNC_QUERY, '0, 1'b0, bhdt_pkg::KEY_UF);
    send_item(bhdt_pkg::FUNC_TICK, 14'h000A, 1'b0, '0);
    send_item(bhdt_pkg::FUNC_TICK, 14'h000A, 1'b0, '0);
    send_item(bhdt_pkg::FUNC_QUERY, '0, 1'b0, bhdt_pkg::KEY_SDF);
    send_item(bhdt_pkg::FUNC_QUERY, '0, 1'b0, bhdt_pkg::KEY_SDB);
    send_item(bhdt_pkg::FUNC_QUERY, '0, 1'b0, bhdt_pkg::KEY_SUF);
    send_item(bhdt_pkg::FUNC_TICK, 14'h3FF0, 1'b1, 6'h3F);
    send_item(bhdt_pkg::FUNC_QUERY, '0, 1'b0, bhdt_pkg::KEY_BTN_FIRST);
    send_item(bhdt_pkg::FUNC_QUERY, '0, 1'b0, bhdt_pkg::KEY_BTN_LAST);
    send_item(bhdt_pkg::FUNC_QUERY, '0, 1'b0, bhdt_pkg::KEY_NEG_FIRST);
    send_item(bhdt_pkg::FUNC_QUERY, '0, 1'b0, bhdt_pkg::KEY_NEG_LAST);
    send_item(bhdt_pkg::FUNC_QUERY, '0, 1'b0, bhdt_pkg::KEY_NEG_LAST + 6'd1);
    send_item(bhdt_pkg::FUNC_QUERY, 14'h3FFF, 1'b1, 6'h3F);
    wait_results_clear();

    // Hold one pattern for a long run, then sweep the key codes both ways
    for (int n = 0; n < RUN_TICKS; n++) send_item(bhdt_pkg::FUNC_TICK, 14'h1555, 1'b0, '0);
    for (int k = 0; k < 64; k++) send_item(bhdt_pkg::FUNC_QUERY, '0, 1'b0, 6'(k));
    send_item(bhdt_pkg::FUNC_TICK, 14'h2AAA, 1'b0, '0);
    for (int k = 0; k < 40; k++) send_item(bhdt_pkg::FUNC_QUERY, '0, 1'b0, 6'(k));
    wait_results_clear();

    // Random phases with different idle and stall mixes
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = IDLE_PCT[ph];
      stall_pct = STALL_PCT[ph];
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        if (ph == 0 && n == 100) begin
          hold_seq <= hold_seq + 1;
          for (int q = 0; q < 30; q++) send_item(bhdt_pkg::FUNC_QUERY, '0, 1'b0, pick_key());
        end
        if (ph == 2 && n == 120) wait_results_clear();
        random_item();
      end
      wait_results_clear();
    end

    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("button_hold_duration_tracker verification clean");
    end else begin
      $display("button_hold_duration_tracker verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/bhdt_pkg.sv
sv/bhdt_counters.sv
sv/bhdt_query.sv
sv/button_hold_duration_tracker.sv
sim/duration_checker.sv
sim/tb.sv
